@@ rtl/nrlp_pkg.sv @@
package nrlp_pkg;

   // ASCII codes used by the line scanner
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChComma  = 8'h2C;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChA      = 8'h41;
   localparam logic [7:0] ChV      = 8'h56;

   // field numbers of the sentence
   localparam logic [3:0] FldTime  = 4'd1;
   localparam logic [3:0] FldStat  = 4'd2;
   localparam logic [3:0] FldLat   = 4'd3;
   localparam logic [3:0] FldLon   = 4'd5;
   localparam logic [3:0] FldSpeed = 4'd7;
   localparam logic [3:0] FldLast  = 4'd13;

   // number scanner modes
   localparam logic [1:0] NumInt  = 2'd0;
   localparam logic [1:0] NumFrac = 2'd1;
   localparam logic [1:0] NumDone = 2'd2;

   // checksum phases
   localparam logic [1:0] PhBody = 2'd0;
   localparam logic [1:0] PhHi   = 2'd1;
   localparam logic [1:0] PhLo   = 2'd2;
   localparam logic [1:0] PhDone = 2'd3;

   localparam logic [1:0] FixValid = 2'b01;
   localparam logic [1:0] FixVoid  = 2'b00;
   localparam logic [1:0] FixOther = 2'b11;

   // reciprocal multipliers for division by constants
   localparam logic [17:0] RecDiv100  = 18'd167773;     // >> 24, x < 2^17
   localparam logic [20:0] RecDiv1000 = 21'd1073742;    // >> 30, x < 2^20
   localparam logic [27:0] RecDiv60   = 28'd143165577;  // >> 33, x < 1e8
   localparam logic [31:0] RecDiv125  = 32'd2199023256; // >> 38, x < 2^31

   localparam logic [29:0] UdegMax  = 30'd999999999;
   localparam logic [22:0] SpeedMax = 23'd8388607;
   localparam logic [16:0] SecMax   = 17'd99999;

   typedef struct packed {
      logic [1:0]  fix;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [16:0] sec_ms;
      logic [29:0] lat;
      logic [29:0] lon;
      logic [22:0] speed;
   } res_type;

   // one event per accepted byte, carried down the conversion pipe
   typedef struct packed {
      logic        vld;
      logic        start;
      logic        tok;
      logic        lend;
      logic        ok;
      logic [3:0]  fld;
      logic        nonempty;
      logic        len6;
      logic [1:0]  fix;
      logic [6:0]  hpart;
      logic [6:0]  mpart;
      logic [31:0] acc;
      logic [19:0] frac;
      logic [2:0]  fdig;
      logic [19:0] fm;
      logic        big;
      logic [34:0] q100;
      logic [39:0] ks;
      logic [40:0] q1000;
      logic [9:0]  whole;
      logic [6:0]  rem;
      logic        ks_sat;
      logic [43:0] ka;
      logic [35:0] kb;
      logic [16:0] sec;
      logic [6:0]  hour;
      logic [26:0] mm;
      logic [29:0] wm;
      logic [30:0] z;
      logic [54:0] p60;
      logic [62:0] p125;
   } pipe_type;

   // 10^(6-n): scales a fraction of n digits to millionths
   function automatic logic [19:0] frac_scale(input logic [2:0] n);
      logic [19:0] r;
      unique case (n)
         3'd0: r = 20'd1000000;
         3'd1: r = 20'd100000;
         3'd2: r = 20'd10000;
         3'd3: r = 20'd1000;
         3'd4: r = 20'd100;
         3'd5: r = 20'd10;
         default: r = 20'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? 8'(ChZero + 8'(v)) : 8'(ChA + 8'(v) - 8'd10);
   endfunction

endpackage

@@ rtl/nmea_rmc_line_parser_unit.sv @@
// A line-ending byte gives its result through the scanner register, then
// four conversion stages, then the result register.
// Throughput: one byte per cycle; the input and the conversion pipe stall only
// while the result register holds an untaken result.
// Reset: synchronous; clears scan state, held fix record, registers to defaults.
module nmea_rmc_line_parser_unit
   import nrlp_pkg::*;
#(
   parameter int LINE_MAX = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] fix_state, [8:2] hour, [15:9] minute, [32:16] second_ms,
   // [62:33] latitude_udeg, [92:63] longitude_udeg, [115:93] speed_mm_s, rest 0
   output logic [119:0] rsp_tdata,
   output logic         rsp_tuser,   // [0] line_ok
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int LenW = $clog2(LINE_MAX);

   logic [4:0]  offset_ff;
   logic [15:0] scale_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 5'd2;
         scale_ff  <= 16'd33715;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2]) scale_ff <= csr_pwdata[15:0];
         else offset_ff <= csr_pwdata[4:0];
      end
   end
   assign csr_prdata = csr_paddr[2] ? {16'd0, scale_ff} : {27'd0, offset_ff};

   // scanner state
   logic [LenW-1:0] len_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  xor_ff, c0_ff, c1_ff, first_ff, tfirst_ff, tlen_ff;
   logic [3:0]  field_ff;
   logic        cut_ff;
   logic [6:0]  hp_ff, mp_ff;
   logic [1:0]  mode_ff;
   logic [2:0]  fd_ff;
   logic [31:0] acc_ff;
   logic [19:0] frac_ff;

   logic [LenW-1:0] len_next;
   logic        start, adv, accept;
   logic [1:0]  b_phase, n_phase, n_mode, b_mode;
   logic [7:0]  b_xor, n_xor, b_c0, n_c0, b_c1, n_c1, b_first, b_tfirst, n_tfirst;
   logic [7:0]  b_tlen, n_tlen;
   logic [3:0]  b_field, n_field;
   logic        b_cut, n_cut, is_dig;
   logic [6:0]  b_hp, n_hp, b_mp, n_mp;
   logic [2:0]  b_fd, n_fd;
   logic [31:0] b_acc, n_acc;
   logic [19:0] b_frac, n_frac;
   logic [35:0] acc_mul;
   logic [7:0]  rx;
   pipe_type    ev;

   assign rx     = req_tdata;
   assign adv    = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign accept = req_tvalid && adv;
   assign start  = (len_ff == '0);

   // scanner next state for the byte on the input
   always_comb begin
      b_phase  = start ? PhBody : phase_ff;
      b_xor    = start ? 8'd0 : xor_ff;
      b_c0     = start ? 8'd0 : c0_ff;
      b_c1     = start ? 8'd0 : c1_ff;
      b_field  = start ? 4'd0 : field_ff;
      b_cut    = start ? 1'b0 : cut_ff;
      b_tlen   = start ? 8'd0 : tlen_ff;
      b_tfirst = start ? 8'd0 : tfirst_ff;
      b_hp     = start ? 7'd0 : hp_ff;
      b_mp     = start ? 7'd0 : mp_ff;
      b_mode   = start ? NumInt : mode_ff;
      b_fd     = start ? 3'd0 : fd_ff;
      b_acc    = start ? 32'd0 : acc_ff;
      b_frac   = start ? 20'd0 : frac_ff;
      b_first  = start ? rx : first_ff;
      n_phase = b_phase; n_xor = b_xor; n_c0 = b_c0; n_c1 = b_c1;
      n_field = b_field; n_cut = b_cut; n_tlen = b_tlen; n_tfirst = b_tfirst;
      n_hp = b_hp; n_mp = b_mp; n_mode = b_mode; n_fd = b_fd;
      n_acc = b_acc; n_frac = b_frac;
      is_dig  = (rx >= ChZero) && (rx <= ChNine);
      acc_mul = 36'd0;
      ev      = '0;
      ev.tok  = 1'b0;
      if (!b_cut) begin
         if (rx == 8'd0) begin
            n_cut = 1'b1;
         end else begin
            // checksum capture
            unique case (b_phase)
               PhBody: begin
                  if (rx == ChStar) n_phase = PhHi;
                  else if (!start) n_xor = b_xor ^ rx;
               end
               PhHi: begin
                  n_c0 = rx; n_phase = PhLo;
               end
               PhLo: begin
                  n_c1 = rx; n_phase = PhDone;
               end
               default: ;
            endcase
            if (rx == ChComma) begin
               ev.tok  = 1'b1;
               n_field = (b_field >= FldLast) ? 4'd0 : 4'(b_field + 4'd1);
               n_tlen = 8'd0; n_tfirst = 8'd0; n_hp = 7'd0; n_mp = 7'd0;
               n_mode = NumInt; n_fd = 3'd0; n_acc = 32'd0; n_frac = 20'd0;
            end else begin
               if (b_tlen == 8'd0) n_tfirst = rx;
               // time field: split hour and minute digit pairs
               if (b_field == FldTime && b_tlen == 8'd2) begin
                  n_hp = b_acc[6:0];
                  n_mode = NumInt; n_fd = 3'd0; n_acc = 32'd0; n_frac = 20'd0;
               end
               if (b_field == FldTime && b_tlen == 8'd4) begin
                  n_mp = b_acc[6:0];
                  n_mode = NumInt; n_fd = 3'd0; n_acc = 32'd0; n_frac = 20'd0;
               end
               // number scan
               acc_mul = {n_acc, 3'b000} + {3'b000, n_acc, 1'b0} + 36'(rx - ChZero);
               unique case (n_mode)
                  NumInt: begin
                     if (is_dig) n_acc = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                : acc_mul[31:0];
                     else if (rx == ChDot) n_mode = NumFrac;
                     else n_mode = NumDone;
                  end
                  NumFrac: begin
                     if (is_dig) begin
                        if (n_fd < 3'd6) begin
                           n_frac = 20'(n_frac * 20'd10 + 20'(rx - ChZero));
                           n_fd   = 3'(n_fd + 3'd1);
                        end
                     end else begin
                        n_mode = NumDone;
                     end
                  end
                  default: ;
               endcase
               if (b_tlen != 8'hFF) n_tlen = 8'(b_tlen + 8'd1);
            end
         end
      end
      len_next = LenW'(len_ff + 1'b1);
      ev.vld   = accept;
      ev.start = start;
      ev.tok   = ev.tok && accept;
      ev.lend  = (rx == ChLf) || (len_next >= LenW'(LINE_MAX - 1));
      ev.ok    = (len_next > LenW'(6)) && (b_first == ChDollar) && (n_phase != PhBody)
                 && (n_c0 == hex_char(n_xor[7:4])) && (n_c1 == hex_char(n_xor[3:0]));
      ev.fld      = b_field;
      ev.nonempty = (b_tlen != 8'd0);
      ev.len6     = (b_tlen >= 8'd6);
      ev.fix      = (b_tlen == 8'd1 && b_tfirst == ChA) ? FixValid :
                    (b_tlen == 8'd1 && b_tfirst == ChV) ? FixVoid : FixOther;
      ev.hpart = b_hp;
      ev.mpart = b_mp;
      ev.acc   = b_acc;
      ev.frac  = b_frac;
      ev.fdig  = b_fd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; phase_ff <= PhBody; xor_ff <= 8'd0; c0_ff <= 8'd0; c1_ff <= 8'd0;
         first_ff <= 8'd0; tfirst_ff <= 8'd0; tlen_ff <= 8'd0; field_ff <= 4'd0;
         cut_ff <= 1'b0; hp_ff <= 7'd0; mp_ff <= 7'd0; mode_ff <= NumInt;
         fd_ff <= 3'd0; acc_ff <= 32'd0; frac_ff <= 20'd0;
      end else if (accept) begin
         len_ff <= ev.lend ? '0 : len_next;
         phase_ff <= n_phase; xor_ff <= n_xor; c0_ff <= n_c0; c1_ff <= n_c1;
         first_ff <= b_first; tfirst_ff <= n_tfirst; tlen_ff <= n_tlen;
         field_ff <= n_field; cut_ff <= n_cut; hp_ff <= n_hp; mp_ff <= n_mp;
         mode_ff <= n_mode; fd_ff <= n_fd; acc_ff <= n_acc; frac_ff <= n_frac;
      end
   end

   // conversion pipe
   pipe_type p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   pipe_type p1_in, p2_in, p3_in, p4_in;
   logic [23:0] kn;
   logic [7:0]  hsum;

   // stage 1: fraction scale, /100 product, knots times scale
   always_comb begin
      p1_in      = p0_ff;
      kn         = (p0_ff.acc > 32'd10000000) ? 24'd10000000 : p0_ff.acc[23:0];
      p1_in.fm   = 20'(p0_ff.frac * frac_scale(p0_ff.fdig));
      p1_in.big  = (p0_ff.acc >= 32'd100000);
      p1_in.q100 = p0_ff.acc[16:0] * RecDiv100;
      p1_in.ks   = kn * scale_ff;
   end

   // stage 2: quotient and remainder, /1000 product, speed partials
   always_comb begin
      p2_in        = p1_ff;
      p2_in.q1000  = p1_ff.fm * RecDiv1000;
      p2_in.whole  = p1_ff.q100[33:24];
      p2_in.rem    = 7'(p1_ff.acc[16:0] - 17'(p1_ff.q100[33:24] * 7'd100));
      p2_in.ks_sat = (p1_ff.ks >= 40'd549755814);
      p2_in.ka     = p1_ff.ks[29:0] * 14'd15625;
      p2_in.kb     = p1_ff.fm * scale_ff;
   end

   // stage 3: time values, minutes in millionths, speed numerator
   always_comb begin
      p3_in     = p2_ff;
      p3_in.sec = (p2_ff.acc >= 32'd100) ? SecMax :
                  17'(17'(p2_ff.acc[6:0] * 10'd1000) + 17'(p2_ff.q1000[39:30]));
      hsum       = 8'(p2_ff.hpart) + 8'(offset_ff);
      p3_in.hour = (hsum > 8'd127) ? 7'd127 : hsum[6:0];
      p3_in.mm   = 27'(27'(p2_ff.rem * 20'd1000000) + 27'(p2_ff.fm));
      p3_in.wm   = 30'(p2_ff.whole * 20'd1000000);
      p3_in.z    = 31'(({p2_ff.ka, 6'b000000} + 50'(p2_ff.kb)) >> 19);
   end

   // stage 4: /60 and /125 products
   always_comb begin
      p4_in      = p3_ff;
      p4_in.p60  = p3_ff.mm * RecDiv60;
      p4_in.p125 = p3_ff.z * RecDiv125;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff.vld <= 1'b0; p1_ff.vld <= 1'b0; p2_ff.vld <= 1'b0;
         p3_ff.vld <= 1'b0; p4_ff.vld <= 1'b0;
      end else if (adv) begin
         p0_ff <= ev; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in; p4_ff <= p4_in;
      end
   end

   // apply to pending and held records, form result
   res_type     pend_ff, held_ff, out_ff, pb, pn, hn;
   logic        out_vld_ff, ok_ff;
   logic [30:0] dsum;
   logic [29:0] udeg;
   logic [24:0] sp;
   logic [22:0] speed;

   always_comb begin
      dsum  = 31'(p4_ff.wm) + 31'(p4_ff.p60[54:33]);
      udeg  = (p4_ff.big || dsum > 31'(UdegMax)) ? UdegMax : dsum[29:0];
      sp    = p4_ff.p125[62:38];
      speed = (p4_ff.ks_sat || sp > 25'(SpeedMax)) ? SpeedMax : sp[22:0];
      pb    = p4_ff.start ? held_ff : pend_ff;
      pn    = pb;
      if (p4_ff.tok) begin
         unique case (p4_ff.fld)
            FldTime: begin
               if (p4_ff.len6) begin
                  pn.hour = p4_ff.hour; pn.minute = p4_ff.mpart; pn.sec_ms = p4_ff.sec;
               end
            end
            FldStat: pn.fix = p4_ff.fix;
            FldLat:  if (p4_ff.nonempty) pn.lat = udeg;
            FldLon:  if (p4_ff.nonempty) pn.lon = udeg;
            FldSpeed: begin
               if (pb.fix != FixValid) pn.speed = 23'd0;
               else if (p4_ff.nonempty) pn.speed = speed;
            end
            default: ;
         endcase
      end
      hn = (p4_ff.lend && p4_ff.ok) ? pn : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         held_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= p4_ff.vld && p4_ff.lend;
         if (p4_ff.vld) begin
            pend_ff <= pn;
            held_ff <= hn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= hn;
         ok_ff  <= p4_ff.ok;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {4'd0, out_ff.speed, out_ff.lon, out_ff.lat, out_ff.sec_ms,
                        out_ff.minute, out_ff.hour, out_ff.fix};

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff < LenW'(LINE_MAX - 1)) else $error("line length overrun");
   a_field_bound: assert property (@(posedge clock) disable iff (reset)
      field_ff <= FldLast) else $error("field number overrun");
   a_fix_code: assert property (@(posedge clock) disable iff (reset)
      held_ff.fix != 2'b10) else $error("bad held fix code");
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(p4_ff.vld && p4_ff.lend))
      else $error("result without line end");

endmodule
